### design/chil_pkg.sv
// ----------------------------------------------------------------------------
// chil_pkg
// shared types and constants of the chained hash index lookup
// ----------------------------------------------------------------------------
package chil_pkg;

	localparam int Entries = 1024;
	localparam int SlotW = $clog2(Entries);
	localparam int CountW = SlotW + 1;
	localparam logic [15:0] EndMark = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_LOADED  = 3'd0,
		ST_FOUND   = 3'd1,
		ST_MISS    = 3'd2,
		ST_INVALID = 3'd3,
		ST_OVERRUN = 3'd4
	} status_t;

	// one classified item between front and back
	typedef struct packed {
		logic        lookup;
		logic [9:0]  slot;
		logic [15:0] target_entry;
		logic [15:0] link_slot;
		logic [31:0] entry_id;
		logic [31:0] key;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [9:0] found_entry;
	} result_t;

endpackage

### design/chil_ram.sv
// ----------------------------------------------------------------------------
// chil_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module chil_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/chil_front.sv
// ----------------------------------------------------------------------------
// chil_front
// input skid and two-entry queue feeding the lookup engine
// ----------------------------------------------------------------------------
module chil_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  chil_pkg::item_t in_item,
	output logic          q_valid,
	input  logic          q_ready,
	output chil_pkg::item_t q_item
);
	import chil_pkg::*;

	item_t      buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### design/chil_modu.sv
// ----------------------------------------------------------------------------
// chil_modu
// restoring key modulo count, one quotient bit per cycle
// ----------------------------------------------------------------------------
module chil_modu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 key,
	input  logic [chil_pkg::CountW-1:0] count,
	output logic                        done,
	output logic [chil_pkg::CountW-1:0] rem
);
	import chil_pkg::*;

	logic [31:0]     dvd_q;
	logic [CountW:0] rem_q;
	logic [5:0]      bit_q;
	logic            busy_q;
	logic [CountW:0] shl;
	logic [CountW:0] dif;

	assign shl  = {rem_q[CountW-1:0], dvd_q[31]};
	assign dif  = shl - {1'b0, count};
	assign rem  = rem_q[CountW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				dvd_q  <= key;
				rem_q  <= '0;
				bit_q  <= 6'd0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[30:0], 1'b0};
				rem_q <= dif[CountW] ? shl : dif;
				bit_q <= bit_q + 6'd1;
				if (bit_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

### design/chil_back.sv
// ----------------------------------------------------------------------------
// chil_back
// executes loads and walks chains through the index and id memories
// ----------------------------------------------------------------------------
module chil_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [chil_pkg::CountW-1:0] count,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  chil_pkg::item_t             q_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output chil_pkg::result_t           out_res
);
	import chil_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MOD, S_RDSLOT, S_RDID, S_CMP, S_OUT
	} state_t;

	state_t              state_q;
	logic [31:0]         key_q;
	logic [SlotW-1:0]    idx_q;
	logic [15:0]         tgt_q;
	logic [CountW-1:0]   steps_q;
	logic [CountW-1:0]   cnt_eff;
	logic                we;
	logic [15:0]         tgt_rd, link_rd;
	logic [31:0]         id_rd;
	logic                mod_start, mod_done;
	logic [CountW-1:0]   mod_rem;
	logic [SlotW-1:0]    slot_raddr;
	logic [SlotW-1:0]    id_raddr;

	assign cnt_eff = (count > CountW'(Entries)) ? CountW'(Entries) : count;
	assign q_ready = (state_q == S_IDLE) && !out_valid;
	assign we      = q_valid && q_ready && !q_item.lookup;
	assign mod_start = q_valid && q_ready && q_item.lookup && (cnt_eff != '0);
	assign slot_raddr = idx_q;
	// target comes straight from the slot read so the id is ready at compare
	assign id_raddr   = tgt_rd[SlotW-1:0];

	chil_ram #(.Width(16), .Depth(Entries)) u_tgt (
		.clk, .we, .waddr(q_item.slot[SlotW-1:0]), .wdata(q_item.target_entry),
		.raddr(slot_raddr), .rdata(tgt_rd));
	chil_ram #(.Width(16), .Depth(Entries)) u_link (
		.clk, .we, .waddr(q_item.slot[SlotW-1:0]), .wdata(q_item.link_slot),
		.raddr(slot_raddr), .rdata(link_rd));
	chil_ram #(.Width(32), .Depth(Entries)) u_id (
		.clk, .we, .waddr(q_item.slot[SlotW-1:0]), .wdata(q_item.entry_id),
		.raddr(id_raddr), .rdata(id_rd));

	chil_modu u_mod (
		.clk, .arst_n, .start(mod_start), .key(q_item.key), .count(cnt_eff),
		.done(mod_done), .rem(mod_rem));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			out_res   <= '{status: ST_LOADED, found_entry: '0};
			key_q     <= '0;
			idx_q     <= '0;
			tgt_q     <= '0;
			steps_q   <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						key_q   <= q_item.key;
						steps_q <= '0;
						if (!q_item.lookup) begin
							out_valid <= 1'b1;
							out_res   <= '{status: ST_LOADED, found_entry: '0};
						end else if (cnt_eff == '0) begin
							out_valid <= 1'b1;
							out_res   <= '{status: ST_MISS, found_entry: '0};
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						idx_q   <= mod_rem[SlotW-1:0];
						state_q <= S_RDSLOT;
					end
				end
				S_RDSLOT: state_q <= S_RDID;
				S_RDID: begin
					// slot data valid now; check target while its id is read
					tgt_q <= tgt_rd;
					if (tgt_rd == EndMark || {1'b0, tgt_rd} >= {6'd0, cnt_eff}) begin
						out_res <= '{status: ST_INVALID, found_entry: '0};
						state_q <= S_OUT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_OUT;
					if (id_rd == key_q) begin
						out_res <= '{status: ST_FOUND, found_entry: tgt_q[9:0]};
					end else if (steps_q == CountW'(Entries - 1)) begin
						out_res <= '{status: ST_OVERRUN, found_entry: '0};
					end else if (link_rd == EndMark) begin
						out_res <= '{status: ST_MISS, found_entry: '0};
					end else if ({1'b0, link_rd} >= {6'd0, cnt_eff}) begin
						out_res <= '{status: ST_INVALID, found_entry: '0};
					end else begin
						idx_q   <= link_rd[SlotW-1:0];
						steps_q <= steps_q + CountW'(1);
						state_q <= S_RDSLOT;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/chained_hash_index_lookup_core.sv
// ----------------------------------------------------------------------------
// chained_hash_index_lookup_core
// chained hash index lookup over one bank of 1024 slots
// ----------------------------------------------------------------------------
// load or zero count: result registered as the queue hands the word to the back end
// lookup: the bit-serial key modulo, then for each visited slot a slot read, an id
//   read and a compare, then a final state that hands the result to the output
// one item at a time in the back end; a two-word queue in front keeps accepting
// async active-low reset clears control and entry_count; memories stay unset
module chained_hash_index_lookup_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [10:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata, // slot, target_entry, link_slot, entry_id, key, zero pad
	input  logic         s_tuser, // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata  // status, found_entry, zero pad
);
	import chil_pkg::*;

	logic [CountW-1:0] count_q;
	item_t             in_item, q_item;
	logic              q_valid, q_ready;
	result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	always_comb begin
		in_item.lookup       = s_tuser;
		in_item.slot         = s_tdata[9:0];
		in_item.target_entry = s_tdata[25:10];
		in_item.link_slot    = s_tdata[41:26];
		in_item.entry_id     = s_tdata[73:42];
		in_item.key          = s_tdata[105:74];
	end

	chil_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
		.q_valid, .q_ready, .q_item);

	chil_back u_back (
		.clk, .arst_n, .count(count_q), .q_valid, .q_ready, .q_item,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res));

	assign m_tdata = {3'd0, res.found_entry, res.status};

`ifndef SYNTHESIS
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status != ST_FOUND |-> res.found_entry == '0)
		else $error("found_entry nonzero without hit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(res))
		else $error("result changed while stalled");
`endif

endmodule

### verif/chained_hash_index_lookup_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_index_lookup_core_test
// loads index slots and looks up keys through their chains under random idle
// gaps and back pressure; every result word is checked against a local
// predictor of the slot table, the id table and the entry count
// ----------------------------------------------------------------------------
module chained_hash_index_lookup_core_test;
	import chil_pkg::*;

	typedef struct {
		bit        lookup;
		bit [9:0]  slot;
		bit [15:0] target_entry;
		bit [15:0] link_slot;
		bit [31:0] entry_id;
		bit [31:0] key;
	} index_op_t;

	typedef struct {
		status_t  status;
		bit [9:0] found_entry;
	} lookup_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [111:0] s_word;  // slot, target_entry, link_slot, entry_id, key, zero pad
	logic        s_tuser;  // action
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // status, found_entry, zero pad

	chained_hash_index_lookup_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_word),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// table state as the block should hold it
	bit [15:0] tbl_target [Entries];
	bit [15:0] tbl_link [Entries];
	bit [31:0] tbl_id [Entries];
	bit        tbl_written [Entries];
	bit [10:0] entry_count;

	index_op_t   op_queue [$];
	lookup_res_t res_pending [$];
	lookup_res_t res_expected [$];

	int  mismatches;
	bit  src_pause;
	bit  no_idle;
	bit  hold_req;
	int  hold_cnt;
	bit  s_rdy_q, m_vld_q, cfg_rdy_q;
	logic [15:0] m_data_q;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ready/valid are sampled mid-cycle and used at the following rising edge
	always @(negedge clk) begin
		s_rdy_q <= s_tready;
		m_vld_q <= m_tvalid;
		m_data_q <= m_tdata;
		cfg_rdy_q <= cfg_ready;
	end

	// chain walk; also reports whether it touched a slot never loaded
	function automatic status_t walk_chain(input bit [31:0] key, output bit [9:0] hit,
			output bit unsafe);
		int count;
		int idx;
		int tgt;
		hit = '0;
		unsafe = 1'b0;
		count = (entry_count > Entries) ? Entries : entry_count;
		if (count == 0)
			return ST_MISS;
		idx = key % count;
		for (int n = 0; n < Entries; n++) begin
			if (idx == EndMark)
				return ST_MISS;
			if (idx >= count)
				return ST_INVALID;
			if (!tbl_written[idx])
				unsafe = 1'b1;
			tgt = tbl_target[idx];
			if (tgt == EndMark || tgt >= count)
				return ST_INVALID;
			if (!tbl_written[tgt])
				unsafe = 1'b1;
			if (tbl_id[tgt] == key) begin
				hit = tgt[9:0];
				return ST_FOUND;
			end
			idx = tbl_link[idx];
		end
		return ST_OVERRUN;
	endfunction

	// predicts the op's result in order and queues it with the op
	function automatic void issue_op(input index_op_t op);
		lookup_res_t r;
		bit unsafe;
		if (!op.lookup) begin
			tbl_target[op.slot] = op.target_entry;
			tbl_link[op.slot] = op.link_slot;
			tbl_id[op.slot] = op.entry_id;
			tbl_written[op.slot] = 1'b1;
			r.status = ST_LOADED;
			r.found_entry = '0;
		end else
			r.status = walk_chain(op.key, r.found_entry, unsafe);
		op_queue.push_back(op);
		res_pending.push_back(r);
	endfunction

	function automatic index_op_t load_op(input int slot, input int tgt, input int lnk,
			input bit [31:0] id);
		index_op_t op;
		op.lookup = 1'b0;
		op.slot = slot[9:0];
		op.target_entry = tgt[15:0];
		op.link_slot = lnk[15:0];
		op.entry_id = id;
		op.key = $urandom;
		return op;
	endfunction

	function automatic index_op_t find_op(input bit [31:0] key);
		index_op_t op;
		op.lookup = 1'b1;
		op.slot = $urandom;
		op.target_entry = $urandom;
		op.link_slot = $urandom;
		op.entry_id = $urandom;
		op.key = key;
		return op;
	endfunction

	function automatic void random_load(input int span);
		int slot, tgt, lnk, r;
		slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, Entries - 1)
			: $urandom_range(0, span - 1);
		r = $urandom_range(0, 9);
		if (r == 0)
			tgt = EndMark;
		else if (r == 1)
			tgt = $urandom_range(0, 65535);
		else
			tgt = $urandom_range(0, span - 1);
		r = $urandom_range(0, 99);
		if (r < 45)
			lnk = EndMark;
		else if (r < 85)
			lnk = $urandom_range(0, span - 1);
		else if (r < 92)
			lnk = slot;
		else
			lnk = $urandom_range(0, 65535);
		issue_op(load_op(slot, tgt, lnk, $urandom));
	endfunction

	// tries keys that start on loaded slots; falls back to a load
	function automatic void random_lookup(input int span);
		bit [63:0] k;
		bit [31:0] key;
		bit [9:0] hit;
		bit unsafe;
		status_t st;
		int count, t;
		count = (entry_count > Entries) ? Entries : entry_count;
		for (int tries = 0; tries < 40; tries++) begin
			if (count == 0 || $urandom_range(0, 3) == 0)
				key = $urandom;
			else if ($urandom_range(0, 1) == 0) begin
				t = $urandom_range(0, count - 1);
				key = tbl_id[t];
			end else begin
				k = {32'd0, $urandom};
				k = k - (k % count) + $urandom_range(0, count - 1);
				if (k > 64'hFFFF_FFFF)
					k = k - count;
				key = k[31:0];
			end
			st = walk_chain(key, hit, unsafe);
			if (unsafe)
				continue;
			if (st == ST_OVERRUN && $urandom_range(0, 7) != 0)
				continue;
			issue_op(find_op(key));
			return;
		end
		random_load(span);
	endfunction

	task automatic drain(input int extra);
		while (op_queue.size() != 0 || res_pending.size() != 0 || res_expected.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_count(input bit [10:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_rdy_q);
		cfg_valid <= 1'b0;
		entry_count = value;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		index_op_t op;
		bit fire;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_word <= '0;
			s_tuser <= 1'b0;
		end else begin
			fire = s_tvalid && s_rdy_q;
			if (fire)
				res_expected.push_back(res_pending.pop_front());
			if (!s_tvalid || fire) begin
				if (op_queue.size() == 0 || src_pause
						|| (!no_idle && $urandom_range(0, 99) < 33))
					s_tvalid <= 1'b0;
				else begin
					op = op_queue.pop_front();
					s_word <= {6'd0, op.key, op.entry_id, op.link_slot,
						op.target_entry, op.slot};
					s_tuser <= op.lookup;
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		lookup_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (m_tready && m_vld_q) begin
				if (res_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", m_data_q);
				end else begin
					want = res_expected.pop_front();
					if (m_data_q[2:0] !== want.status
							|| m_data_q[12:3] !== want.found_entry) begin
						mismatches++;
						if (mismatches <= 10)
							$display("status exp %0d got %0d, entry exp %0d got %0d",
								want.status, m_data_q[2:0], want.found_entry,
								m_data_q[12:3]);
					end
				end
			end
			if (hold_req && hold_cnt == 0) begin
				hold_cnt <= 400;
				m_tready <= 1'b0;
			end else if (hold_cnt > 1) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= no_idle || $urandom_range(0, 99) >= 33;
		end
	end

	initial begin
		int counts [7];
		int span;
		counts = '{1, 7, 64, 1024, 2047, 300, 3};
		mismatches = 0;
		src_pause = 1'b0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		entry_count = '0;
		for (int i = 0; i < Entries; i++) begin
			tbl_target[i] = '0;
			tbl_link[i] = '0;
			tbl_id[i] = '0;
			tbl_written[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;

		// count zero misses everything
		issue_op(find_op(32'h0));
		issue_op(find_op(32'hFFFF_FFFF));
		issue_op(load_op(0, 0, EndMark, 32'h0));
		issue_op(load_op(1, 2, 3, 32'hFFFF_FFFF));
		issue_op(load_op(2, 1, 0, 32'h8000_0001));
		issue_op(load_op(3, EndMark, EndMark, 32'h5555_5555));
		issue_op(load_op(1023, 1023, 1023, 32'hAAAA_AAAA));
		issue_op(find_op(32'h0));
		drain(20);
		write_count(11'd4);
		issue_op(find_op(32'h0));          // hit at the head
		issue_op(find_op(32'h8000_0001));  // slot 1 -> entry 2, hit on first step
		issue_op(find_op(32'h8000_0005));  // slot 1 -> 3, invalid target
		issue_op(find_op(32'hFFFF_FFFF));  // slot 3 invalid target
		issue_op(find_op(32'h1234_5672));  // slot 2 -> 0, ends in a miss
		issue_op(load_op(0, 0, 0, 32'h0)); // self link, endless chain
		issue_op(find_op(32'h0000_0004));
		issue_op(load_op(2, 9, 0, 32'h8000_0001));
		issue_op(find_op(32'h0000_0006)); // target past the count
		issue_op(load_op(0, 3, EndMark, 32'h0));
		issue_op(find_op(32'h0000_0008));
		drain(20);

		for (int ph = 0; ph < 7; ph++) begin
			write_count(counts[ph][10:0]);
			span = (counts[ph] > Entries) ? Entries : counts[ph];
			no_idle = (ph == 2);
			for (int n = 0; n < 132; n++) begin
				if ($urandom_range(0, 99) < 45)
					random_load(span);
				else
					random_lookup(span);
				if (ph == 1 && n == 60) begin
					hold_req = 1'b1;
					wait (hold_cnt != 0);
					hold_req = 1'b0;
				end
				if (ph == 5 && n == 70) begin
					src_pause = 1'b1;
					while (res_expected.size() != 0 || (s_tvalid && s_rdy_q === 1'b0))
						@(posedge clk);
					repeat (5) @(posedge clk);
					while (res_expected.size() != 0)
						@(posedge clk);
					src_pause = 1'b0;
				end
			end
			drain(20);
		end
		write_count(11'd0);
		issue_op(find_op($urandom));
		drain(50);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#150ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
